[sv/rdmm_pkg.sv]
// Shared types and constants for the region-decoded memory map.
package rdmm_pkg;

   localparam int FLASH_BANK_BYTES = 262144;
   localparam int SRAM_BANK_BYTES  = 524288;

   localparam int LANES       = 4;
   localparam int FLASH_OFF_W = $clog2(FLASH_BANK_BYTES);
   localparam int SRAM_OFF_W  = $clog2(SRAM_BANK_BYTES);
   localparam int FLASH_ROWS  = FLASH_BANK_BYTES / LANES;
   localparam int SRAM_ROWS   = SRAM_BANK_BYTES / LANES;
   localparam int FLASH_ROW_W = FLASH_OFF_W - 2;
   localparam int SRAM_ROW_W  = SRAM_OFF_W - 2;
   localparam int STORE_ROWS  = 2 * SRAM_ROWS + 2 * FLASH_ROWS;
   localparam int STORE_ROW_W = $clog2(STORE_ROWS);

   localparam logic [STORE_ROW_W-1:0] SRA_ROW_BASE = '0;
   localparam logic [STORE_ROW_W-1:0] SRB_ROW_BASE = STORE_ROW_W'(SRAM_ROWS);
   localparam logic [STORE_ROW_W-1:0] FLA_ROW_BASE = STORE_ROW_W'(2 * SRAM_ROWS);
   localparam logic [STORE_ROW_W-1:0] FLB_ROW_BASE =
      STORE_ROW_W'(2 * SRAM_ROWS + FLASH_ROWS);
   localparam logic [STORE_ROW_W-1:0] LAST_ROW = STORE_ROW_W'(STORE_ROWS - 1);

   localparam logic [1:0] OP_WORD_READ  = 2'd0;
   localparam logic [1:0] OP_WORD_WRITE = 2'd1;
   localparam logic [1:0] OP_BYTE_READ  = 2'd2;
   localparam logic [1:0] OP_BYTE_WRITE = 2'd3;

   localparam logic [31:0] FLA_LO = 32'h0008_0000;
   localparam logic [31:0] FLA_HI = 32'h000B_FFFF;
   localparam logic [31:0] FLB_LO = 32'h000C_0000;
   localparam logic [31:0] FLB_HI = 32'h000F_FFFF;
   localparam logic [31:0] ROM_LO = 32'h0010_0000;
   localparam logic [31:0] ROM_HI = 32'h001F_FFFF;
   localparam logic [31:0] RSV_LO = 32'h0020_0000;
   localparam logic [31:0] RSV_HI = 32'h1FFF_FFFF;
   localparam logic [31:0] SRA_LO = 32'h2000_0000;
   localparam logic [31:0] SRA_HI = 32'h2007_FFFF;
   localparam logic [31:0] SRB_LO = 32'h2008_0000;
   localparam logic [31:0] SRB_HI = 32'h200F_FFFF;
   localparam logic [31:0] UND_LO = 32'h2020_0000;
   localparam logic [31:0] UND_HI = 32'h3FFF_FFFF;

   typedef struct packed {
      logic                                rd_en;
      logic [LANES-1:0]                    wr_en;
      logic [LANES-1:0][STORE_ROW_W-1:0]   row;
      logic [LANES-1:0][7:0]               wdata;
   } store_req_type;

endpackage

[sv/region_decoded_memory_map_core.sv]
// Top level of the region-decoded memory map: address decode, permission check and response.
// A response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; a stalled response holds off the next request.
// Reset: synchronous; afterward the stores are swept to zero one row per cycle over all
// 393216 rows, during which no request is accepted.
// The ROM window has no storage: nothing can write it, so it always reads as zero.
module region_decoded_memory_map_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_allowed
);
   import rdmm_pkg::*;

   logic                  accept;
   logic                  busy;
   logic                  is_write;
   logic                  is_byte;
   logic                  in_fla, in_flb, in_rom, in_sra, in_srb, in_rsv, in_und;
   logic                  mapped;
   logic                  ok;
   logic [1:0]            lane;
   logic [1:0]            byte_idx;
   logic                  carry;
   logic [FLASH_ROW_W-1:0] flash_row;
   logic [SRAM_ROW_W-1:0]  sram_row;
   store_req_type         store_req;
   logic [LANES-1:0][7:0] rd_data;
   logic [31:0]           word;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        allowed_ff;
   logic        read_hit_ff;
   logic        byte_ff;
   logic [1:0]  lane_ff;

   assign req_stall = busy || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_write = (req_operation == OP_WORD_WRITE) || (req_operation == OP_BYTE_WRITE);
      is_byte  = (req_operation == OP_BYTE_READ) || (req_operation == OP_BYTE_WRITE);
      in_fla   = (req_address >= FLA_LO) && (req_address <= FLA_HI);
      in_flb   = (req_address >= FLB_LO) && (req_address <= FLB_HI);
      in_rom   = (req_address >= ROM_LO) && (req_address <= ROM_HI);
      in_sra   = (req_address >= SRA_LO) && (req_address <= SRA_HI);
      in_srb   = (req_address >= SRB_LO) && (req_address <= SRB_HI);
      in_rsv   = (req_address >= RSV_LO) && (req_address <= RSV_HI);
      in_und   = (req_address >= UND_LO) && (req_address <= UND_HI);
      mapped   = in_fla || in_flb || in_sra || in_srb;
      ok       = !in_rsv && !in_und && !(is_write && in_rom);
      lane     = req_address[1:0];
   end

   // Each lane holds the bytes whose bank offset has those two low bits; lanes below the
   // starting lane belong to the next row, which wraps inside the bank.
   always_comb begin
      store_req.rd_en = accept;
      for (int j = 0; j < LANES; j++) begin
         carry     = 2'(j) < lane;
         byte_idx  = 2'(j) - lane;
         flash_row = FLASH_ROW_W'(req_address[FLASH_OFF_W-1:2] + FLASH_ROW_W'(carry));
         sram_row  = SRAM_ROW_W'(req_address[SRAM_OFF_W-1:2] + SRAM_ROW_W'(carry));
         if (in_fla) begin
            store_req.row[j] = FLA_ROW_BASE + STORE_ROW_W'(flash_row);
         end else if (in_flb) begin
            store_req.row[j] = FLB_ROW_BASE + STORE_ROW_W'(flash_row);
         end else if (in_srb) begin
            store_req.row[j] = SRB_ROW_BASE + STORE_ROW_W'(sram_row);
         end else begin
            store_req.row[j] = SRA_ROW_BASE + STORE_ROW_W'(sram_row);
         end
         store_req.wdata[j] = req_write_data[8*byte_idx +: 8];
         store_req.wr_en[j] = accept && ok && mapped && is_write
                              && (!is_byte || (2'(j) == lane));
      end
   end

   rdmm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .busy      (busy),
      .rd_data   (rd_data)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         allowed_ff  <= ok;
         read_hit_ff <= ok && mapped && !is_write;
         byte_ff     <= is_byte;
         lane_ff     <= lane;
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         word[8*i +: 8] = rd_data[2'(lane_ff + 2'(i))];
      end
      if (!read_hit_ff) begin
         rsp_read_data = '0;
      end else if (byte_ff) begin
         rsp_read_data = {24'h000000, rd_data[lane_ff]};
      end else begin
         rsp_read_data = word;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allowed = allowed_ff;

endmodule

[sv/rdmm_store.sv]
// Byte-lane store for the flash and SRAM banks with a clearing sweep after reset.
module rdmm_store (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rdmm_pkg::store_req_type                 store_req,
   output logic                                    busy,
   output logic [rdmm_pkg::LANES-1:0][7:0]         rd_data
);
   import rdmm_pkg::*;

   logic                   clearing_ff, clearing_in;
   logic [STORE_ROW_W-1:0] clear_row_ff, clear_row_in;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_row_in = clear_row_ff;
      if (clearing_ff) begin
         clear_row_in = clear_row_ff + 1'b1;
         if (clear_row_ff == LAST_ROW) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_row_ff <= clear_row_in;
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [7:0] lane_mem [STORE_ROWS];
      logic [7:0] rd_byte_ff;

      always_ff @(posedge clock) begin
         if (clearing_ff) begin
            lane_mem[clear_row_ff] <= 8'h00;
         end else if (store_req.wr_en[j]) begin
            lane_mem[store_req.row[j]] <= store_req.wdata[j];
         end
         if (store_req.rd_en) begin
            rd_byte_ff <= lane_mem[store_req.row[j]];
         end
      end

      assign rd_data[j] = rd_byte_ff;
   end

   assign busy = clearing_ff;

endmodule

[bench/memory_map_checker.sv]
// Checker for the memory map: it predicts each reply from the requests it sees and compares.
module memory_map_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_read_data,
   input  logic        rsp_allowed,
   output int          mismatch_count,
   output int          replies_due_count,
   output int          replies_compared,
   output int          refusals_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import rdmm_pkg::*;

   localparam int unsigned ROM_SPAN = 1048576;

   typedef enum logic [2:0] {
      NO_BANK,
      FLASH_A,
      FLASH_B,
      ROM_AREA,
      SRAM_A,
      SRAM_B
   } bank_sel_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        allowed;
   } bus_reply_type;

   logic [7:0] stored_bytes [logic [22:0]];
   bus_reply_type replies_due [$];

   function automatic bit in_window(input logic [31:0] a, input logic [31:0] lo,
                                    input logic [31:0] hi);
      return a >= lo && a <= hi;
   endfunction

   function automatic void locate_bank(input logic [31:0] a, output bank_sel_type bank,
                                       output logic [31:0] origin, output int unsigned span);
      bank = NO_BANK;
      origin = '0;
      span = 1;
      if (in_window(a, FLA_LO, FLA_HI)) begin
         bank = FLASH_A;
         origin = FLA_LO;
         span = FLASH_BANK_BYTES;
      end else if (in_window(a, FLB_LO, FLB_HI)) begin
         bank = FLASH_B;
         origin = FLB_LO;
         span = FLASH_BANK_BYTES;
      end else if (in_window(a, ROM_LO, ROM_HI)) begin
         bank = ROM_AREA;
         origin = ROM_LO;
         span = ROM_SPAN;
      end else if (in_window(a, SRA_LO, SRA_HI)) begin
         bank = SRAM_A;
         origin = SRA_LO;
         span = SRAM_BANK_BYTES;
      end else if (in_window(a, SRB_LO, SRB_HI)) begin
         bank = SRAM_B;
         origin = SRB_LO;
         span = SRAM_BANK_BYTES;
      end
   endfunction

   function automatic bus_reply_type access_memory_map(input logic [1:0] op,
                                                       input logic [31:0] addr,
                                                       input logic [31:0] wdata);
      bank_sel_type  bank;
      logic [31:0]   origin;
      int unsigned   span;
      int unsigned   lanes;
      int unsigned   offset;
      int unsigned   idx;
      bit            writing;
      bit            readable;
      bit            ok;
      logic [22:0]   key;
      bus_reply_type reply;
      writing = (op == OP_WORD_WRITE) || (op == OP_BYTE_WRITE);
      lanes = (op == OP_BYTE_READ || op == OP_BYTE_WRITE) ? 1 : 4;
      readable = !in_window(addr, RSV_LO, RSV_HI) && !in_window(addr, UND_LO, UND_HI);
      ok = writing ? (readable && !in_window(addr, ROM_LO, ROM_HI)) : readable;
      locate_bank(addr, bank, origin, span);
      reply.read_data = '0;
      reply.allowed = ok;
      if (ok && bank != NO_BANK) begin
         offset = (addr - origin) % span;
         for (int i = 0; i < lanes; i++) begin
            idx = (offset + i) % span;
            key = {bank, idx[19:0]};
            if (writing) begin
               stored_bytes[key] = wdata[8*i +: 8];
            end else if (stored_bytes.exists(key)) begin
               reply.read_data[8*i +: 8] = stored_bytes[key];
            end
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      bus_reply_type want;
      if (reset) begin
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            replies_due.push_back(access_memory_map(req_operation, req_address,
                                                    req_write_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("reply with no request outstanding: read_data %h allowed %b",
                      rsp_read_data, rsp_allowed);
               mismatch_count++;
            end else begin
               want = replies_due.pop_front();
               replies_compared++;
               if (!want.allowed) begin
                  refusals_seen++;
               end
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  mismatch_count++;
               end
               if (rsp_allowed !== want.allowed) begin
                  $error("allowed: expected %b, got %b", want.allowed, rsp_allowed);
                  mismatch_count++;
               end
            end
         end
      end
      replies_due_count = replies_due.size();
   end

endmodule

[bench/tb.sv]
// Top of the memory map bench: clock, reset, request and reply traffic, and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rdmm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = OP_WORD_READ;
   logic [31:0] req_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_allowed;

   int mismatch_count;
   int replies_due_count;
   int replies_compared;
   int refusals_seen;

   bit req_taken;
   bit calm;
   bit hold_asked;
   int requests_sent;
   int directed_count;

   region_decoded_memory_map_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_allowed    (rsp_allowed)
   );

   memory_map_checker u_map_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_allowed       (rsp_allowed),
      .mismatch_count    (mismatch_count),
      .replies_due_count (replies_due_count),
      .replies_compared  (replies_compared),
      .refusals_seen     (refusals_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
   end

   task automatic offer(input logic [1:0] op, input logic [31:0] addr,
                        input logic [31:0] data);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_write_data <= data;
      @(negedge clock);
      while (!req_taken) begin
         @(negedge clock);
      end
      requests_sent++;
   endtask

   function automatic logic [31:0] bank_offset(input int unsigned span);
      case ($urandom_range(2))
         0: return $urandom_range(63);
         1: return span - 1 - $urandom_range(7);
         default: return $urandom_range(span - 1);
      endcase
   endfunction

   initial begin : reply_side
      int hold_left;
      bit hold_served;
      hold_left = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_asked && !hold_served) begin
            hold_left = 400;
            hold_served = 1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 32;
         end
      end
   end

   initial begin : request_side
      logic [1:0]  op;
      logic [31:0] addr;
      int unsigned roll;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer(OP_WORD_WRITE, FLA_LO, 32'hFFFF_FFFF);
      offer(OP_WORD_READ, FLA_LO, 32'h0000_0000);
      offer(OP_BYTE_WRITE, FLB_HI, 32'h1234_56A5);
      offer(OP_BYTE_READ, FLB_HI, 32'hFFFF_FFFF);
      offer(OP_WORD_WRITE, FLB_HI - 1, 32'h89AB_CDEF);
      offer(OP_WORD_READ, FLB_LO, 32'h0000_0000);
      offer(OP_WORD_WRITE, SRA_HI - 2, 32'h1122_3344);
      offer(OP_WORD_READ, SRA_LO, 32'h0000_0000);
      offer(OP_WORD_READ, SRA_HI - 2, 32'h0000_0000);
      offer(OP_WORD_WRITE, SRB_LO, 32'hDEAD_BEEF);
      offer(OP_BYTE_READ, SRB_LO + 3, 32'h0000_0000);
      offer(OP_WORD_WRITE, ROM_LO, 32'hFFFF_FFFF);
      offer(OP_WORD_READ, ROM_LO, 32'h0000_0000);
      offer(OP_BYTE_WRITE, ROM_HI, 32'h0000_00FF);
      offer(OP_BYTE_READ, ROM_HI, 32'h0000_0000);
      offer(OP_WORD_READ, RSV_LO, 32'h0000_0000);
      offer(OP_BYTE_WRITE, RSV_HI, 32'hFFFF_FFFF);
      offer(OP_BYTE_READ, UND_LO, 32'h0000_0000);
      offer(OP_WORD_WRITE, UND_HI, 32'hFFFF_FFFF);
      offer(OP_WORD_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
      offer(OP_WORD_READ, 32'h0000_0000, 32'h0000_0000);
      offer(OP_BYTE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(OP_BYTE_READ, 32'hFFFF_FFFF, 32'h0000_0000);
      offer(OP_WORD_READ, 32'h2200_0000, 32'h0000_0000);
      offer(OP_WORD_WRITE, 32'h4200_0000, 32'h5A5A_5A5A);
      directed_count = requests_sent;

      for (int n = 0; n < 1600; n++) begin
         calm = (n >= 400 && n < 600);
         if (n == 1000) begin
            hold_asked = 1;
         end
         op = 2'($urandom_range(3));
         roll = $urandom_range(99);
         if (roll < 14) begin
            addr = FLA_LO + bank_offset(FLASH_BANK_BYTES);
         end else if (roll < 26) begin
            addr = FLB_LO + bank_offset(FLASH_BANK_BYTES);
         end else if (roll < 50) begin
            addr = SRA_LO + bank_offset(SRAM_BANK_BYTES);
         end else if (roll < 68) begin
            addr = SRB_LO + bank_offset(SRAM_BANK_BYTES);
         end else if (roll < 75) begin
            addr = ROM_LO + bank_offset(ROM_HI - ROM_LO + 1);
         end else if (roll < 81) begin
            addr = RSV_LO + $urandom_range(RSV_HI - RSV_LO);
         end else if (roll < 87) begin
            addr = UND_LO + $urandom_range(UND_HI - UND_LO);
         end else if (roll < 91) begin
            addr = $urandom_range(FLA_LO - 1);
         end else if (roll < 94) begin
            addr = SRB_HI + 1 + $urandom_range(UND_LO - SRB_HI - 2);
         end else begin
            addr = $urandom;
         end
         offer(op, addr, $urandom);
      end
      req_valid <= 1'b0;

      while (replies_due_count != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      $display("Run covered %0d requests, %0d of them directed, over flash, ROM, SRAM,",
               requests_sent, directed_count);
      $display("refused and unmapped ranges: %0d replies compared, %0d refused, %0d mismatches.",
               replies_compared, refusals_seen, mismatch_count);
      if (mismatch_count == 0 && replies_due_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
sv/rdmm_pkg.sv
sv/rdmm_store.sv
sv/region_decoded_memory_map_core.sv
bench/memory_map_checker.sv
bench/tb.sv
